[hdl/nfa_set_simulator_unit_defines.svh]
// Assertion macros shared by the set simulator RTL.
`ifndef NFA_SET_SIMULATOR_UNIT_DEFINES_SVH
`define NFA_SET_SIMULATOR_UNIT_DEFINES_SVH

// Same-cycle implication, checked outside reset.
`define NSS_ASSERT_IMPL(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("nss assertion failed");

// Next-cycle implication, checked outside reset.
`define NSS_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("nss assertion failed");

`endif

[hdl/nss_pkg.sv]
// Types, constants and the symbol decoder of the NFA set simulator.
package nss_pkg;

  localparam int MAX_STATES_DEF = 32;
  localparam int ALPHABET_SIZE  = 36;
  localparam int SYM_W          = $clog2(ALPHABET_SIZE);

  localparam logic [7:0] CHAR_LOWER_A = 8'd97;
  localparam logic [7:0] CHAR_LOWER_Z = 8'd122;
  localparam logic [7:0] CHAR_DIGIT_0 = 8'd48;
  localparam logic [7:0] CHAR_DIGIT_9 = 8'd57;
  localparam logic [7:0] DIGIT_OFFSET = 8'd22;

  localparam logic [2:0] CMD_ADD     = 3'd0;
  localparam logic [2:0] CMD_MARK    = 3'd1;
  localparam logic [2:0] CMD_RESTART = 3'd2;
  localparam logic [2:0] CMD_FEED    = 3'd3;
  localparam logic [2:0] CMD_ALL     = 3'd4;

  typedef struct packed {
    logic [2:0] cmd;
    logic [4:0] src_state;
    logic [7:0] symbol_char;
    logic [4:0] dst_state;
    logic       accept_value;
  } in_item_t;

  typedef struct packed {
    logic [31:0] active_set;
    logic        accepted;
    logic        bad_symbol;
  } out_item_t;

  typedef struct packed {
    logic             ok;
    logic [SYM_W-1:0] idx;
  } sym_t;

  // Control side of the transition memory port.
  typedef struct packed {
    logic             rd_en;
    logic [SYM_W-1:0] rd_addr;
    logic             wr_en;
    logic [SYM_W-1:0] wr_addr;
  } mem_req_t;

  // Map a-z to 0..25 and 0-9 to 26..35; anything else is not a symbol.
  function automatic sym_t sym_decode(logic [7:0] ch);
    sym_t       r;
    logic [7:0] off;
    r   = '0;
    off = '0;
    if (ch >= CHAR_LOWER_A && ch <= CHAR_LOWER_Z) begin
      off   = ch - CHAR_LOWER_A;
      r.ok  = 1'b1;
      r.idx = off[SYM_W-1:0];
    end else if (ch >= CHAR_DIGIT_0 && ch <= CHAR_DIGIT_9) begin
      off   = ch - DIGIT_OFFSET;
      r.ok  = 1'b1;
      r.idx = off[SYM_W-1:0];
    end
    return r;
  endfunction

endpackage

[hdl/nss_trans_mem.sv]
// Symbol-indexed transition memory with per-row valid bits and registered read.
`include "nfa_set_simulator_unit_defines.svh"

module nss_trans_mem import nss_pkg::*; #(
  parameter int MaxStates = MAX_STATES_DEF,
  parameter int RowW      = MaxStates * MaxStates
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  mem_req_t        req_i,
  input  logic [RowW-1:0] wr_data_i,
  output logic [RowW-1:0] rd_data_o
);

  logic [RowW-1:0]          mem_q [ALPHABET_SIZE];
  logic [ALPHABET_SIZE-1:0] row_valid_q;
  logic [RowW-1:0]          rd_data_q;
  logic                     rd_valid_q;

  always_ff @(posedge clk_i) begin
    if (req_i.wr_en) begin
      mem_q[req_i.wr_addr] <= wr_data_i;
    end
    if (req_i.rd_en) begin
      rd_data_q <= mem_q[req_i.rd_addr];
    end
  end

  // A row never written reads as the empty set.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      row_valid_q <= '0;
      rd_valid_q  <= 1'b0;
    end else begin
      if (req_i.wr_en) begin
        row_valid_q[req_i.wr_addr] <= 1'b1;
      end
      if (req_i.rd_en) begin
        rd_valid_q <= row_valid_q[req_i.rd_addr];
      end
    end
  end

  assign rd_data_o = rd_valid_q ? rd_data_q : '0;

  `NSS_ASSERT_IMPL(a_no_rw_same_row, clk_i, rst_ni, req_i.rd_en && req_i.wr_en,
                   req_i.rd_addr != req_i.wr_addr)
  `NSS_ASSERT_IMPL(a_rd_in_range, clk_i, rst_ni, req_i.rd_en,
                   int'(req_i.rd_addr) < ALPHABET_SIZE)
  `NSS_ASSERT_IMPL(a_wr_in_range, clk_i, rst_ni, req_i.wr_en,
                   int'(req_i.wr_addr) < ALPHABET_SIZE)

endmodule

[hdl/nss_next_set.sv]
// Union of the transition sets of all active states for one symbol row.
module nss_next_set import nss_pkg::*; #(
  parameter int MaxStates = MAX_STATES_DEF,
  parameter int RowW      = MaxStates * MaxStates
) (
  input  logic [RowW-1:0]      row_i,
  input  logic [MaxStates-1:0] active_i,
  output logic [MaxStates-1:0] next_o
);

  logic [MaxStates-1:0] col [MaxStates];

  // Gather, for each destination, the bit of every source set.
  always_comb begin
    for (int d = 0; d < MaxStates; d++) begin
      for (int s = 0; s < MaxStates; s++) begin
        col[d][s] = row_i[s*MaxStates + d];
      end
      next_o[d] = |(col[d] & active_i);
    end
  end

endmodule

[hdl/nfa_set_simulator_unit.sv]
// Top level of the NFA set simulator: sequencer, state registers and output register.
//
//  channel  direction  handshake                 payload
//  in       input      in_valid_i / in_stall_o   in_data_i  (in_item_t)
//  out      output     out_valid_o / out_stall_i out_data_o (out_item_t)
//
// Every command but 4 reads its transition memory row, then updates and, for command 0, writes
// it back. Command 4 reads every symbol row in turn, pipelined with write back.
// Reset clears the active set to state 0, the accepting mask and all row valid bits at once.
// A result that cannot be delivered is held; the block then takes no new item until it leaves.
`include "nfa_set_simulator_unit_defines.svh"

module nfa_set_simulator_unit import nss_pkg::*; #(
  parameter int MaxStates = MAX_STATES_DEF
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      in_valid_i,
  output logic      in_stall_o,
  input  in_item_t  in_data_i,
  output logic      out_valid_o,
  input  logic      out_stall_i,
  output out_item_t out_data_o
);

  localparam int RowW    = MaxStates * MaxStates;
  localparam int BitIdxW = $clog2(RowW);
  localparam logic [SYM_W-1:0] LastSym = SYM_W'(ALPHABET_SIZE - 1);

  typedef enum logic [3:0] {
    ST_IDLE = 4'b0001,
    ST_EXEC = 4'b0010,
    ST_ALL  = 4'b0100,
    ST_DLV  = 4'b1000
  } state_e;

  state_e               state_q, state_d;
  logic [SYM_W-1:0]     k_q, k_d;
  logic [MaxStates-1:0] act_q, act_d;
  logic [MaxStates-1:0] acc_q, acc_d;
  in_item_t             item_q;
  out_item_t            res_q, res_d;
  out_item_t            fin_item, out_next;
  logic                 out_valid_q;
  out_item_t            out_data_q;

  mem_req_t             mreq;
  logic [RowW-1:0]      row, wdata, set_mask;
  logic [MaxStates-1:0] next_set;
  logic [BitIdxW-1:0]   bit_idx;
  sym_t                 in_sym, item_sym;
  logic                 in_accept, slot_free, edge_ok, finish, bad, load_out;

  assign in_accept = in_valid_i && !in_stall_o;
  assign in_stall_o = (state_q != ST_IDLE);
  assign slot_free = !out_valid_q || !out_stall_i;
  assign in_sym = sym_decode(in_data_i.symbol_char);
  assign item_sym = sym_decode(item_q.symbol_char);

  assign edge_ok = (int'(item_q.src_state) < MaxStates) &&
                   (int'(item_q.dst_state) < MaxStates);
  assign bit_idx = BitIdxW'(int'(item_q.src_state) * MaxStates + int'(item_q.dst_state));
  assign set_mask = {{(RowW-1){1'b0}}, 1'b1} << bit_idx;
  assign wdata = row | set_mask;

  nss_trans_mem #(
    .MaxStates(MaxStates),
    .RowW     (RowW)
  ) u_mem (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .req_i    (mreq),
    .wr_data_i(wdata),
    .rd_data_o(row)
  );

  nss_next_set #(
    .MaxStates(MaxStates),
    .RowW     (RowW)
  ) u_next (
    .row_i   (row),
    .active_i(act_q),
    .next_o  (next_set)
  );

  always_comb begin
    state_d  = state_q;
    k_d      = k_q;
    act_d    = act_q;
    acc_d    = acc_q;
    res_d    = res_q;
    mreq     = '0;
    finish   = 1'b0;
    bad      = 1'b0;
    load_out = 1'b0;
    out_next = res_q;

    unique case (state_q)
      ST_IDLE: begin
        if (in_accept) begin
          mreq.rd_en   = 1'b1;
          mreq.rd_addr = (in_data_i.cmd == CMD_ALL) ? '0 : in_sym.idx;
          k_d          = '0;
          state_d      = (in_data_i.cmd == CMD_ALL) ? ST_ALL : ST_EXEC;
        end
      end
      ST_EXEC: begin
        finish = 1'b1;
        case (item_q.cmd)
          CMD_ADD: begin
            bad          = !item_sym.ok;
            mreq.wr_en   = item_sym.ok && edge_ok;
            mreq.wr_addr = item_sym.idx;
          end
          CMD_MARK: begin
            if (item_q.accept_value && int'(item_q.src_state) < MaxStates) begin
              acc_d = acc_q | (MaxStates'(1) << item_q.src_state);
            end
          end
          CMD_RESTART: act_d = MaxStates'(1);
          CMD_FEED: begin
            bad = !item_sym.ok;
            if (item_sym.ok) begin
              act_d = next_set;
            end
          end
          default: ;
        endcase
      end
      ST_ALL: begin
        // Write back row k while reading row k+1.
        mreq.wr_en   = edge_ok;
        mreq.wr_addr = k_q;
        if (k_q == LastSym) begin
          finish = 1'b1;
        end else begin
          mreq.rd_en   = 1'b1;
          mreq.rd_addr = k_q + 1'b1;
          k_d          = k_q + 1'b1;
        end
      end
      ST_DLV: begin
        if (slot_free) begin
          load_out = 1'b1;
          state_d  = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase

    fin_item.active_set = 32'(act_d);
    fin_item.accepted   = |(act_d & acc_d);
    fin_item.bad_symbol = bad;

    if (finish) begin
      if (slot_free) begin
        load_out = 1'b1;
        out_next = fin_item;
        state_d  = ST_IDLE;
      end else begin
        res_d   = fin_item;
        state_d = ST_DLV;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      k_q         <= '0;
      act_q       <= MaxStates'(1);
      acc_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      k_q     <= k_d;
      act_q   <= act_d;
      acc_q   <= acc_d;
      if (load_out) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_accept) begin
      item_q <= in_data_i;
    end
    res_q <= res_d;
    if (load_out) begin
      out_data_q <= out_next;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_data_q;

  `NSS_ASSERT_IMPL(a_dlv_slot_busy, clk_i, rst_ni, state_q == ST_DLV, out_valid_q)
  `NSS_ASSERT_NEXT(a_accept_starts_work, clk_i, rst_ni, in_accept,
                   state_q == ST_EXEC || state_q == ST_ALL)
  `NSS_ASSERT_IMPL(a_all_count_range, clk_i, rst_ni, state_q == ST_ALL,
                   int'(k_q) < ALPHABET_SIZE)
  `NSS_ASSERT_IMPL(a_acc_monotone, clk_i, rst_ni, $past(rst_ni),
                   (acc_q & $past(acc_q)) == $past(acc_q))

endmodule
